// ----- rtl/cnf_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package cnf_pkg;

   // Width of the converted word.
   localparam int WORD_BITS = 32;
   // Decimal digits needed for WORD_BITS bits: ceil(WORD_BITS * log10(2)).
   localparam int DEC_DIGITS = ((WORD_BITS * 1233) >> 12) + 1;
   // BCD/nibble buffer width; also holds every hex nibble of the word.
   localparam int DIG_BITS = 4 * DEC_DIGITS;
   localparam int CNT_BITS = $clog2(DEC_DIGITS + 1);
   localparam int BIT_CNT_BITS = $clog2(WORD_BITS);

   localparam logic [1:0] ACT_RAW  = 2'd0;
   localparam logic [1:0] ACT_SDEC = 2'd1;
   localparam logic [1:0] ACT_UDEC = 2'd2;
   localparam logic [1:0] ACT_HEX  = 2'd3;

   localparam logic [7:0] CHR_CR    = 8'h0D;
   localparam logic [7:0] CHR_LF    = 8'h0A;
   localparam logic [7:0] CHR_SPACE = 8'h20;
   localparam logic [7:0] CHR_MINUS = 8'h2D;
   localparam logic [7:0] CHR_ZERO  = 8'h30;
   localparam logic [7:0] CHR_X     = 8'h78;

   localparam logic [7:0] DIGIT_SET [16] = '{
      8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
      8'h38, 8'h39, 8'h61, 8'h62, 8'h63, 8'h64, 8'h65, 8'h66
   };

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CR,
      ST_CHAR,
      ST_CONV,
      ST_PRE1,
      ST_PRE2,
      ST_SKIP,
      ST_DIGIT,
      ST_SPACE
   } state_type;

endpackage

`default_nettype wire

// ----- rtl/console_number_formatter_top.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Channel   | Ports                              | Handshake
// ----------+------------------------------------+-------------------------------------
// request   | req_action, req_value              | beat taken when start & !busy
// response  | rsp_out_char, rsp_last             | beat on each cycle rsp_valid is high
//
// Sequencing: a raw character is sent as it is, and a newline is sent as CR LF.
// Decimal first runs WORD_BITS shift-and-add-3 steps of the bit-serial binary-to-BCD
// converter, sends a minus sign if negative, then drops leading zeros one at a time,
// finds the first digit, sends each digit and ends with a trailing space.
// Hex skips the converter and sends a 0x prefix first. Each beat leaves the port register
// in the cycle after its state, so the last beat shows in the first idle cycle.
// Reset is synchronous and returns the sequencer to idle with no beat pending.
// The receiver cannot stall: each character is shown for exactly one cycle.
module console_number_formatter_top (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   output logic                               busy,
   input  wire logic [1:0]                    req_action,
   input  wire logic [cnf_pkg::WORD_BITS-1:0] req_value,
   output logic                               rsp_valid,
   output logic [7:0]                         rsp_out_char,
   output logic                               rsp_last
);

   cnf_pkg::state_type state_ff, state_in;

   logic [cnf_pkg::WORD_BITS-1:0]    bin_ff, bin_in;       // binary shift register
   logic [cnf_pkg::DIG_BITS-1:0]     dig_ff, dig_in;       // BCD / nibble shift register
   logic [cnf_pkg::CNT_BITS-1:0]     cnt_ff, cnt_in;       // digits still in dig_ff
   logic [cnf_pkg::BIT_CNT_BITS-1:0] bit_cnt_ff, bit_cnt_in;
   logic [1:0]                       mode_ff, mode_in;
   logic                             neg_ff, neg_in;

   logic                             rsp_valid_ff, rsp_valid_in;
   logic [7:0]                       rsp_char_ff, rsp_char_in;
   logic                             rsp_last_ff, rsp_last_in;

   logic                             accept;
   logic [3:0]                       top_digit;
   logic [cnf_pkg::DIG_BITS-1:0]     dig_adj;

   assign busy      = (state_ff != cnf_pkg::ST_IDLE);
   assign accept    = start && !busy;
   assign top_digit = dig_ff[cnf_pkg::DIG_BITS-1 -: 4];

   // Add 3 to every BCD digit at 5 or above before the next shift.
   always_comb begin
      for (int i = 0; i < cnf_pkg::DEC_DIGITS; i++) begin
         dig_adj[4*i +: 4] = (dig_ff[4*i +: 4] >= 4'd5) ? dig_ff[4*i +: 4] + 4'd3
                                                         : dig_ff[4*i +: 4];
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         cnf_pkg::ST_IDLE: begin
            if (accept) begin
               case (req_action)
                  cnf_pkg::ACT_RAW:
                     state_in = (req_value[7:0] == cnf_pkg::CHR_LF) ? cnf_pkg::ST_CR
                                                                   : cnf_pkg::ST_CHAR;
                  cnf_pkg::ACT_HEX: state_in = cnf_pkg::ST_PRE1;
                  default:          state_in = cnf_pkg::ST_CONV;
               endcase
            end
         end
         cnf_pkg::ST_CR:   state_in = cnf_pkg::ST_CHAR;
         cnf_pkg::ST_CHAR: state_in = cnf_pkg::ST_IDLE;
         cnf_pkg::ST_CONV: begin
            if (bit_cnt_ff == '0) begin
               state_in = neg_ff ? cnf_pkg::ST_PRE1 : cnf_pkg::ST_SKIP;
            end
         end
         cnf_pkg::ST_PRE1: begin
            state_in = (mode_ff == cnf_pkg::ACT_HEX) ? cnf_pkg::ST_PRE2 : cnf_pkg::ST_SKIP;
         end
         cnf_pkg::ST_PRE2: state_in = cnf_pkg::ST_SKIP;
         cnf_pkg::ST_SKIP: begin
            if (top_digit != 4'd0 || cnt_ff == cnf_pkg::CNT_BITS'(1)) begin
               state_in = cnf_pkg::ST_DIGIT;
            end
         end
         cnf_pkg::ST_DIGIT: begin
            if (cnt_ff == cnf_pkg::CNT_BITS'(1)) begin
               state_in = cnf_pkg::ST_SPACE;
            end
         end
         cnf_pkg::ST_SPACE: state_in = cnf_pkg::ST_IDLE;
         default:           state_in = cnf_pkg::ST_IDLE;
      endcase
   end

   // Character beat for the current state; registered before the ports.
   always_comb begin
      rsp_valid_in = 1'b0;
      rsp_char_in  = cnf_pkg::CHR_SPACE;
      rsp_last_in  = 1'b0;
      case (state_ff)
         cnf_pkg::ST_CR: begin
            rsp_valid_in = 1'b1;
            rsp_char_in  = cnf_pkg::CHR_CR;
         end
         cnf_pkg::ST_CHAR: begin
            rsp_valid_in = 1'b1;
            rsp_char_in  = bin_ff[7:0];
            rsp_last_in  = 1'b1;
         end
         cnf_pkg::ST_PRE1: begin
            rsp_valid_in = 1'b1;
            rsp_char_in  = (mode_ff == cnf_pkg::ACT_HEX) ? cnf_pkg::CHR_ZERO
                                                         : cnf_pkg::CHR_MINUS;
         end
         cnf_pkg::ST_PRE2: begin
            rsp_valid_in = 1'b1;
            rsp_char_in  = cnf_pkg::CHR_X;
         end
         cnf_pkg::ST_DIGIT: begin
            rsp_valid_in = 1'b1;
            rsp_char_in  = cnf_pkg::DIGIT_SET[top_digit];
         end
         cnf_pkg::ST_SPACE: begin
            rsp_valid_in = 1'b1;
            rsp_char_in  = cnf_pkg::CHR_SPACE;
            rsp_last_in  = 1'b1;
         end
         default: begin
            rsp_valid_in = 1'b0;
         end
      endcase
   end

   // Datapath next values.
   always_comb begin
      bin_in     = bin_ff;
      dig_in     = dig_ff;
      cnt_in     = cnt_ff;
      bit_cnt_in = bit_cnt_ff;
      mode_in    = mode_ff;
      neg_in     = neg_ff;
      case (state_ff)
         cnf_pkg::ST_IDLE: begin
            if (accept) begin
               mode_in    = req_action;
               neg_in     = (req_action == cnf_pkg::ACT_SDEC) &&
                            req_value[cnf_pkg::WORD_BITS-1];
               // Take the magnitude of a negative signed word up front.
               bin_in     = neg_in ? (~req_value) + cnf_pkg::WORD_BITS'(1) : req_value;
               dig_in     = (req_action == cnf_pkg::ACT_HEX)
                            ? {{(cnf_pkg::DIG_BITS - cnf_pkg::WORD_BITS){1'b0}}, req_value}
                            : '0;
               cnt_in     = cnf_pkg::CNT_BITS'(cnf_pkg::DEC_DIGITS);
               bit_cnt_in = cnf_pkg::BIT_CNT_BITS'(cnf_pkg::WORD_BITS - 1);
            end
         end
         cnf_pkg::ST_CONV: begin
            // Adjust, then shift one binary bit into the BCD register.
            dig_in     = {dig_adj[cnf_pkg::DIG_BITS-2:0], bin_ff[cnf_pkg::WORD_BITS-1]};
            bin_in     = {bin_ff[cnf_pkg::WORD_BITS-2:0], 1'b0};
            bit_cnt_in = bit_cnt_ff - cnf_pkg::BIT_CNT_BITS'(1);
         end
         cnf_pkg::ST_SKIP: begin
            // Drop one leading zero, keeping at least one digit.
            if (top_digit == 4'd0 && cnt_ff != cnf_pkg::CNT_BITS'(1)) begin
               dig_in = {dig_ff[cnf_pkg::DIG_BITS-5:0], 4'd0};
               cnt_in = cnt_ff - cnf_pkg::CNT_BITS'(1);
            end
         end
         cnf_pkg::ST_DIGIT: begin
            // Advance to the next digit after sending this one.
            dig_in = {dig_ff[cnf_pkg::DIG_BITS-5:0], 4'd0};
            cnt_in = cnt_ff - cnf_pkg::CNT_BITS'(1);
         end
         default: begin
            bin_in = bin_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= cnf_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      bin_ff      <= bin_in;
      dig_ff      <= dig_in;
      cnt_ff      <= cnt_in;
      bit_cnt_ff  <= bit_cnt_in;
      mode_ff     <= mode_in;
      neg_ff      <= neg_in;
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_char = rsp_char_ff;
   assign rsp_last     = rsp_last_ff;

   // An accepted request always starts a run.
   assert property (@(posedge clock) disable iff (reset) accept |=> busy)
      else $error("request beat accepted but sequencer stayed idle");

   // A beat that is not the last of its run leaves the sequencer working.
   assert property (@(posedge clock) disable iff (reset) rsp_valid && !rsp_last |-> busy)
      else $error("run cut short before its last beat");

   // The last beat of a run is never followed directly by another beat.
   assert property (@(posedge clock) disable iff (reset) rsp_valid && rsp_last |=> !rsp_valid)
      else $error("beat emitted right after the last beat of a run");

endmodule

`default_nettype wire
